FILE: rtl/dtb_pkg.sv
package dtb_pkg;

    localparam int unsigned CMD_W      = 3;
    localparam int unsigned ID_W       = 4;
    localparam int unsigned DUR_W      = 32;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned TSTATE_W   = 2;
    localparam int unsigned TIME_W     = 64;
    localparam int unsigned MAX_EVENTS = 16;
    localparam int unsigned EVT_CNT_W  = $clog2(MAX_EVENTS + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_START   = 3'd1,
        CMD_RESTART = 3'd2,
        CMD_OPEN    = 3'd3,
        CMD_CLOSE   = 3'd4,
        CMD_QUERY   = 3'd5
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_EXPIRY = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_DONE   = 2'd2
    } kind_t;

    typedef enum logic [TSTATE_W-1:0] {
        ST_CLOSED  = 2'd0,
        ST_RUNNING = 2'd1,
        ST_PASSED  = 2'd2
    } tstate_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIRE = 4'b1000
    } fsm_t;

endpackage

FILE: rtl/dtb_ifs.sv
interface dtb_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [dtb_pkg::CMD_W-1:0]    cmd;
    logic [dtb_pkg::ID_W-1:0]     timer_id;
    logic [dtb_pkg::DUR_W-1:0]    duration;
    logic                         open_flag;
    logic                         repeat_flag;

    modport source (output valid, output cmd, output timer_id, output duration,
                    output open_flag, output repeat_flag, input ready);
    modport sink   (input valid, input cmd, input timer_id, input duration,
                    input open_flag, input repeat_flag, output ready);
endinterface

interface dtb_evt_if;
    logic                         valid;
    logic                         ready;
    logic [dtb_pkg::KIND_W-1:0]   event_kind;
    logic [dtb_pkg::ID_W-1:0]     timer_index;
    logic [dtb_pkg::TSTATE_W-1:0] timer_state;
    logic                         last;

    modport source (output valid, output event_kind, output timer_index,
                    output timer_state, output last, input ready);
    modport sink   (input valid, input event_kind, input timer_index,
                    input timer_state, input last, output ready);
endinterface

FILE: rtl/deadline_timer_bank.sv
// Bank of TIMER_COUNT deadline timers on a 64-bit microsecond counter that
// advances by one on each tick word. Deadlines and periods live in one
// single-port-read memory; the running, periodic and armed flags are
// flip-flops. A start, restart, open, close or query word reads the memory,
// then updates and replies once the output register is free. A tick advances
// the counter and scans the memory once per reported expiry, or once if none
// is due. Each pass reads and ranks every entry, then reports the earliest
// due timer, if any. A tick reports at most 16 timers; the next word is not
// accepted until its last report is loaded, output stalls included. Expiries
// come earliest deadline first, lower index on ties, each timer at most once
// per tick. Reset clears the counter and flags at once and needs no clearing
// pass: unwritten memory entries read as zero. A new word is accepted while a
// finished result still waits in the output register.
module deadline_timer_bank #(
    parameter int TIMER_COUNT = 16,
    parameter int PERIOD_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    dtb_cmd_if.sink       req,
    dtb_evt_if.source     rsp
);

    localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int DW    = dtb_pkg::TIME_W + PERIOD_BITS;
    localparam int TW    = dtb_pkg::TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);
    localparam logic [IDX_W:0]   CNT_END  = (IDX_W + 1)'(TIMER_COUNT);
    localparam logic [dtb_pkg::EVT_CNT_W-1:0] LAST_EVT =
        dtb_pkg::EVT_CNT_W'(dtb_pkg::MAX_EVENTS - 1);

    dtb_pkg::fsm_t state_reg, state_next;

    logic [TW-1:0]          now_reg, now_next;
    logic [TIMER_COUNT-1:0] running_reg, running_next;
    logic [TIMER_COUNT-1:0] periodic_reg, periodic_next;
    logic [TIMER_COUNT-1:0] armed_reg, armed_next;
    logic [TIMER_COUNT-1:0] elig_reg, elig_next;
    logic [TIMER_COUNT-1:0] fired_reg, fired_next;
    logic [dtb_pkg::EVT_CNT_W-1:0] n_reg, n_next;
    logic [IDX_W:0]         scan_cnt_reg, scan_cnt_next;
    logic                   cmp_v_reg, cmp_v_next;
    logic                   first_reg, first_next;
    logic                   found_reg, found_next;
    logic                   out_valid_reg, out_valid_next;

    dtb_pkg::cmd_t          op_reg, op_next;
    logic [IDX_W-1:0]       id_reg, id_next;
    logic [PERIOD_BITS-1:0] dur_reg, dur_next;
    logic                   open_reg, open_next;
    logic                   rpt_reg, rpt_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [TW-1:0]          best_dl_reg, best_dl_next;
    logic [PERIOD_BITS-1:0] best_pd_reg, best_pd_next;
    logic [dtb_pkg::KIND_W-1:0]   out_kind_reg;
    logic [dtb_pkg::ID_W-1:0]     out_idx_reg;
    logic [dtb_pkg::TSTATE_W-1:0] out_state_reg;
    logic                         out_last_reg;

    logic                   st_rd_en, st_wr_en;
    logic [IDX_W-1:0]       st_rd_addr, st_wr_addr;
    logic [DW-1:0]          st_rd_data, st_wr_data;
    logic [TW-1:0]          rd_dl, new_dl, wr_dl;
    logic [PERIOD_BITS-1:0] rd_pd, add_pd, wr_pd;
    logic                   passed_new, passed_old;

    logic [IDX_W+3:0]       id_wide;
    logic [IDX_W-1:0]       id_addr;
    logic                   id_ok, cmd_ok;
    logic [PERIOD_BITS+31:0] dur_wide;
    logic [PERIOD_BITS-1:0] dur_m;
    logic [IDX_W+3:0]       ld_idx_wide;

    logic                   out_free, load, cand, last_w;
    logic [TIMER_COUNT-1:0] remain;
    dtb_pkg::kind_t         ld_kind;
    logic [IDX_W-1:0]       ld_idx;
    dtb_pkg::tstate_t       ld_state;
    logic                   ld_last;

    dtb_store #(
        .DEPTH (TIMER_COUNT),
        .AW    (IDX_W),
        .DW    (DW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data)
    );

    assign rd_dl = st_rd_data[DW-1 -: TW];
    assign rd_pd = st_rd_data[PERIOD_BITS-1:0];

    assign id_wide  = (IDX_W + 4)'(req.timer_id);
    assign id_addr  = id_wide[IDX_W-1:0];
    assign id_ok    = 32'(req.timer_id) < 32'(TIMER_COUNT);
    assign cmd_ok   = (req.cmd != dtb_pkg::CMD_TICK) && (req.cmd <= dtb_pkg::CMD_QUERY);
    assign dur_wide = (PERIOD_BITS + 32)'(req.duration);
    assign dur_m    = dur_wide[PERIOD_BITS-1:0];

    // shared by start (new period) and restart (stored period)
    assign add_pd     = (op_reg == dtb_pkg::CMD_START) ? dur_reg : rd_pd;
    assign new_dl     = now_reg + TW'(add_pd);
    assign passed_new = now_reg >= new_dl;
    assign passed_old = now_reg >= rd_dl;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == dtb_pkg::S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        now_next      = now_reg;
        running_next  = running_reg;
        periodic_next = periodic_reg;
        armed_next    = armed_reg;
        elig_next     = elig_reg;
        fired_next    = fired_reg;
        n_next        = n_reg;
        scan_cnt_next = scan_cnt_reg;
        cmp_v_next    = 1'b0;
        first_next    = first_reg;
        found_next    = found_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        dur_next      = dur_reg;
        open_next     = open_reg;
        rpt_next      = rpt_reg;
        cmp_idx_next  = cmp_idx_reg;
        best_idx_next = best_idx_reg;
        best_dl_next  = best_dl_reg;
        best_pd_next  = best_pd_reg;

        st_rd_en   = 1'b0;
        st_rd_addr = id_addr;
        st_wr_en   = 1'b0;
        st_wr_addr = id_reg;
        wr_dl      = new_dl;
        wr_pd      = add_pd;

        load     = 1'b0;
        ld_kind  = dtb_pkg::KIND_DONE;
        ld_idx   = id_reg;
        ld_state = dtb_pkg::ST_CLOSED;
        ld_last  = 1'b1;
        cand     = 1'b0;
        last_w   = 1'b0;
        remain   = elig_reg & ~fired_reg;

        unique case (state_reg)
            dtb_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.cmd == dtb_pkg::CMD_TICK)
                    begin
                        now_next      = now_reg + TW'(1);
                        fired_next    = '0;
                        elig_next     = '0;
                        n_next        = '0;
                        scan_cnt_next = '0;
                        first_next    = 1'b1;
                        found_next    = 1'b0;
                        state_next    = dtb_pkg::S_SCAN;
                    end
                    else if (cmd_ok && id_ok)
                    begin
                        op_next    = dtb_pkg::cmd_t'(req.cmd);
                        id_next    = id_addr;
                        dur_next   = (dur_m == '0) ? PERIOD_BITS'(1) : dur_m;
                        open_next  = req.open_flag;
                        rpt_next   = req.repeat_flag;
                        st_rd_en   = 1'b1;
                        state_next = dtb_pkg::S_EXEC;
                    end
                end
            end

            dtb_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = dtb_pkg::S_IDLE;
                    unique case (op_reg)
                        dtb_pkg::CMD_START:
                        begin
                            st_wr_en              = 1'b1;
                            running_next[id_reg]  = open_reg;
                            periodic_next[id_reg] = rpt_reg;
                            armed_next[id_reg]    = 1'b1;
                            if (!open_reg)
                                ld_state = dtb_pkg::ST_CLOSED;
                            else if (passed_new)
                                ld_state = dtb_pkg::ST_PASSED;
                            else
                                ld_state = dtb_pkg::ST_RUNNING;
                        end
                        dtb_pkg::CMD_RESTART:
                        begin
                            st_wr_en             = 1'b1;
                            running_next[id_reg] = 1'b1;
                            ld_state = passed_new ? dtb_pkg::ST_PASSED : dtb_pkg::ST_RUNNING;
                        end
                        dtb_pkg::CMD_OPEN:
                        begin
                            running_next[id_reg] = 1'b1;
                            ld_state = passed_old ? dtb_pkg::ST_PASSED : dtb_pkg::ST_RUNNING;
                        end
                        dtb_pkg::CMD_CLOSE:
                        begin
                            running_next[id_reg] = 1'b0;
                            ld_state = dtb_pkg::ST_CLOSED;
                        end
                        default:
                        begin
                            ld_kind = dtb_pkg::KIND_QUERY;
                            if (!running_reg[id_reg])
                                ld_state = dtb_pkg::ST_CLOSED;
                            else if (passed_old)
                                ld_state = dtb_pkg::ST_PASSED;
                            else
                                ld_state = dtb_pkg::ST_RUNNING;
                        end
                    endcase
                end
            end

            dtb_pkg::S_SCAN:
            begin
                if (scan_cnt_reg < CNT_END)
                begin
                    st_rd_en      = 1'b1;
                    st_rd_addr    = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + (IDX_W + 1)'(1);
                    cmp_v_next    = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[IDX_W-1:0];
                end
                if (cmp_v_reg)
                begin
                    // first pass decides who is due this tick; later passes
                    // only rank the due timers not yet reported
                    if (first_reg)
                        cand = armed_reg[cmp_idx_reg] && running_reg[cmp_idx_reg]
                               && passed_old;
                    else
                        cand = elig_reg[cmp_idx_reg] && !fired_reg[cmp_idx_reg];
                    if (first_reg && cand)
                        elig_next[cmp_idx_reg] = 1'b1;
                    if (cand && (!found_reg || rd_dl < best_dl_reg))
                    begin
                        found_next    = 1'b1;
                        best_idx_next = cmp_idx_reg;
                        best_dl_next  = rd_dl;
                        best_pd_next  = rd_pd;
                    end
                    if (cmp_idx_reg == LAST_IDX)
                        state_next = dtb_pkg::S_FIRE;
                end
            end

            dtb_pkg::S_FIRE:
            begin
                if (!found_reg)
                begin
                    state_next = dtb_pkg::S_IDLE;
                end
                else if (out_free)
                begin
                    remain[best_idx_reg] = 1'b0;
                    last_w   = (remain == '0) || (n_reg == LAST_EVT);
                    load     = 1'b1;
                    ld_kind  = dtb_pkg::KIND_EXPIRY;
                    ld_idx   = best_idx_reg;
                    ld_state = dtb_pkg::ST_PASSED;
                    ld_last  = last_w;
                    fired_next[best_idx_reg] = 1'b1;
                    n_next   = n_reg + dtb_pkg::EVT_CNT_W'(1);
                    if (periodic_reg[best_idx_reg])
                    begin
                        st_wr_en   = 1'b1;
                        st_wr_addr = best_idx_reg;
                        wr_dl      = best_dl_reg + TW'(best_pd_reg);
                        wr_pd      = best_pd_reg;
                    end
                    else
                    begin
                        running_next[best_idx_reg] = 1'b0;
                        armed_next[best_idx_reg]   = 1'b0;
                    end
                    if (last_w)
                    begin
                        state_next = dtb_pkg::S_IDLE;
                    end
                    else
                    begin
                        scan_cnt_next = '0;
                        first_next    = 1'b0;
                        found_next    = 1'b0;
                        state_next    = dtb_pkg::S_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = dtb_pkg::S_IDLE;
            end
        endcase

        if (load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign st_wr_data  = {wr_dl, wr_pd};
    assign ld_idx_wide = (IDX_W + 4)'(ld_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtb_pkg::S_IDLE;
            now_reg       <= '0;
            running_reg   <= '0;
            periodic_reg  <= '0;
            armed_reg     <= '0;
            elig_reg      <= '0;
            fired_reg     <= '0;
            n_reg         <= '0;
            scan_cnt_reg  <= '0;
            cmp_v_reg     <= 1'b0;
            first_reg     <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            running_reg   <= running_next;
            periodic_reg  <= periodic_next;
            armed_reg     <= armed_next;
            elig_reg      <= elig_next;
            fired_reg     <= fired_next;
            n_reg         <= n_next;
            scan_cnt_reg  <= scan_cnt_next;
            cmp_v_reg     <= cmp_v_next;
            first_reg     <= first_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        dur_reg      <= dur_next;
        open_reg     <= open_next;
        rpt_reg      <= rpt_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_dl_reg  <= best_dl_next;
        best_pd_reg  <= best_pd_next;
        if (load)
        begin
            out_kind_reg  <= ld_kind;
            out_idx_reg   <= ld_idx_wide[3:0];
            out_state_reg <= ld_state;
            out_last_reg  <= ld_last;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.event_kind  = out_kind_reg;
    assign rsp.timer_index = out_idx_reg;
    assign rsp.timer_state = out_state_reg;
    assign rsp.last        = out_last_reg;

`ifndef SYNTH
    a_budget: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= dtb_pkg::EVT_CNT_W'(dtb_pkg::MAX_EVENTS))
        else $error("tick reported more expiries than the budget allows");

    a_fired_due: assert property (@(posedge clk) disable iff (!rst_n)
        (fired_reg & ~elig_reg) == '0)
        else $error("timer reported without being due");

    a_more_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtb_pkg::S_FIRE && load && !ld_last) |=> (state_reg == dtb_pkg::S_SCAN))
        else $error("non-final expiry not followed by another scan");

    a_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtb_pkg::S_FIRE && load && !periodic_reg[best_idx_reg])
        |=> !armed_reg[$past(best_idx_reg)] && !running_reg[$past(best_idx_reg)])
        else $error("one-shot timer still armed after expiry");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> out_free)
        else $error("result word overwrote one not yet taken");
`endif

endmodule

FILE: rtl/dtb_store.sv
// Timer entry memory: {deadline, period}. Entries never written read as zero.
module dtb_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 96
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DW-1:0]    rd_q_reg;
    logic             rd_v_reg;
    logic [DEPTH-1:0] written_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg    <= 1'b0;
            written_reg <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_v_reg <= written_reg[rd_addr];
            end
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_v_reg ? rd_q_reg : '0;

endmodule
